// ===== sv/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// No dependencies; imported by text_console_writer, tcw_ctrl and tcw_dp.
`default_nettype none

package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;

	// Field widths fixed by the item format
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 2 * CHAR_W;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int LIN_W  = ROW_W + COL_W + 1;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'h0A;
	localparam logic [CHAR_W-1:0] BACKSPACE_CODE = 8'h08;
	localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'h20;
	localparam logic [CHAR_W-1:0] RESET_ATTR     = 8'h0F;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [CHAR_W-1:0] char_code;
		logic [CHAR_W-1:0] char_attr;
		logic [ROW_W-1:0]  read_row;
		logic [COL_W-1:0]  read_col;
	} in_item_t;

	typedef struct packed {
		logic [COL_W-1:0]  cursor_col_out;
		logic [ROW_W-1:0]  cursor_row_out;
		logic              scrolled;
		logic [CHAR_W-1:0] cell_char;
		logic [CHAR_W-1:0] cell_attr;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic latch_item;
		logic put;
		logic clear_start;
		logic cell_rd;
		logic cell_cap;
		logic sweep_rd;
		logic sweep_wr;
		logic load_out;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] in_op;
		logic       put_scroll;
		logic       cnt_last;
		logic       copy_next;
		logic       sweep_init;
		logic       out_busy;
	} ctrl_sts_t;

	// Linear cell address of a row and column
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		logic [LIN_W-1:0] lin;
		lin = LIN_W'(r) * LIN_W'(COLUMNS) + LIN_W'(c);
		return lin[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/text_console_writer.sv =====
// Text console writer: 25x80 character/attribute store with a cursor.
// After reset the block blanks the store and takes no item meanwhile; write the
// blank_attribute register only while no item is in flight. A put of a character,
// newline or backspace, a read and an unused opcode each pass through ST_PUT, ST_RD or
// ST_DONE to the result register. A put that leaves the bottom row scrolls the store:
// each of the 1920 moved cells is read and then written, and each of the 80 blanked
// ones is written. A clear blanks all 2000 cells. The sweeps are paced by the single
// write port and registered read port of the cell store.
// The result register lets the next item be transferred while a result waits.
// Depends on tcw_pkg, tcw_ctrl, tcw_dp (and tcw_ram through tcw_dp).
`default_nettype none

module text_console_writer
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire in_item_t          in_data,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      out_item_t         out_data,
	input  wire logic              cfg_wr_en,
	input  wire logic [CHAR_W-1:0] cfg_wr_data
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	tcw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tcw_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.out_data   (out_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

`default_nettype wire

// ===== sv/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none

module tcw_ctrl
	import tcw_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output      logic      in_ready,
	input  wire ctrl_sts_t sts,
	output      ctrl_cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_INIT     = 7'b0000001,
		ST_IDLE     = 7'b0000010,
		ST_PUT      = 7'b0000100,
		ST_RD       = 7'b0001000,
		ST_SWEEP_RD = 7'b0010000,
		ST_SWEEP_WR = 7'b0100000,
		ST_DONE     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_wr = 1'b1;
				if (sts.cnt_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_item = 1'b1;
					case (sts.in_op)
						OP_PUT: begin
							state_d = ST_PUT;
						end
						OP_CLEAR: begin
							cmd.clear_start = 1'b1;
							state_d         = ST_SWEEP_WR;
						end
						OP_READ: begin
							cmd.cell_rd = 1'b1;
							state_d     = ST_RD;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_PUT: begin
				cmd.put = 1'b1;
				if (sts.put_scroll) begin
					state_d = ST_SWEEP_RD;
				end else if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_RD: begin
				cmd.cell_cap = 1'b1;
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SWEEP_RD: begin
				cmd.sweep_rd = 1'b1;
				state_d      = ST_SWEEP_WR;
			end
			ST_SWEEP_WR: begin
				cmd.sweep_wr = 1'b1;
				if (sts.cnt_last) begin
					state_d = sts.sweep_init ? ST_IDLE : ST_DONE;
				end else if (sts.copy_next) begin
					state_d = ST_SWEEP_RD;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/tcw_dp.sv =====
// Datapath of the text console writer: cursor, sweep counter, cell store,
// configuration register and result register. Depends on tcw_pkg, tcw_ram.
`default_nettype none

module tcw_dp
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire in_item_t          in_data,
	output      out_item_t         out_data,
	output      logic              out_valid,
	input  wire logic              out_ready,
	input  wire logic              cfg_wr_en,
	input  wire logic [CHAR_W-1:0] cfg_wr_data,
	input  wire ctrl_cmd_t         cmd,
	output      ctrl_sts_t         sts
);

	typedef enum logic [1:0] {
		SW_INIT   = 2'd0,
		SW_CLEAR  = 2'd1,
		SW_SCROLL = 2'd2
	} sweep_kind_t;

	in_item_t          item_q;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	sweep_kind_t       kind_q, kind_d;
	logic              scrolled_q, scrolled_d;
	logic [CELL_W-1:0] cell_q, cell_d;
	logic [CHAR_W-1:0] blank_attr_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	logic              row_inc;
	logic              copy_cur;
	logic              item_in_range;
	logic              new_in_range;
	logic [CHAR_W-1:0] sweep_attr;

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Newline, or an ordinary character in the last column, leaves the row
	always_comb begin
		row_inc = 1'b0;
		if (item_q.char_code == NEWLINE_CODE) begin
			row_inc = 1'b1;
		end else if (item_q.char_code != BACKSPACE_CODE
				&& col_q == COL_W'(COLUMNS - 1)) begin
			row_inc = 1'b1;
		end
	end

	assign copy_cur      = (kind_q == SW_SCROLL) && (cnt_q < ADDR_W'(CELLS - COLUMNS));
	assign item_in_range = (LIN_W'(item_q.read_row) < LIN_W'(ROWS))
		&& (LIN_W'(item_q.read_col) < LIN_W'(COLUMNS));
	assign new_in_range  = (LIN_W'(in_data.read_row) < LIN_W'(ROWS))
		&& (LIN_W'(in_data.read_col) < LIN_W'(COLUMNS));
	assign sweep_attr    = (kind_q == SW_INIT) ? RESET_ATTR : blank_attr_q;

	assign sts.in_op      = in_data.opcode;
	assign sts.put_scroll = row_inc && (row_q == ROW_W'(ROWS - 1));
	assign sts.cnt_last   = (cnt_q == ADDR_W'(CELLS - 1));
	assign sts.copy_next  = (kind_q == SW_SCROLL) && (cnt_q < ADDR_W'(CELLS - COLUMNS - 1));
	assign sts.sweep_init = (kind_q == SW_INIT);
	assign sts.out_busy   = out_valid_q && !out_ready;

	always_comb begin
		col_d      = col_q;
		row_d      = row_q;
		cnt_d      = cnt_q;
		kind_d     = kind_q;
		scrolled_d = scrolled_q;
		cell_d     = cell_q;
		ram_we     = 1'b0;
		ram_waddr  = cell_addr(row_q, col_q);
		ram_wdata  = {item_q.char_attr, item_q.char_code};
		ram_raddr  = '0;

		if (cmd.latch_item) begin
			scrolled_d = 1'b0;
			cell_d     = '0;
		end

		if (cmd.put) begin
			if (item_q.char_code == NEWLINE_CODE) begin
				col_d = '0;
			end else if (item_q.char_code == BACKSPACE_CODE) begin
				if (col_q != '0) begin
					col_d     = col_q - COL_W'(1);
					ram_we    = 1'b1;
					ram_waddr = cell_addr(row_q, col_q - COL_W'(1));
					ram_wdata = {item_q.char_attr, SPACE_CODE};
				end
			end else begin
				ram_we = 1'b1;
				col_d  = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
			end
			if (row_inc) begin
				if (row_q == ROW_W'(ROWS - 1)) begin
					// Stay on the bottom row and start the scroll sweep
					scrolled_d = 1'b1;
					cnt_d      = '0;
					kind_d     = SW_SCROLL;
				end else begin
					row_d = row_q + ROW_W'(1);
				end
			end
		end

		if (cmd.clear_start) begin
			col_d  = '0;
			row_d  = '0;
			cnt_d  = '0;
			kind_d = SW_CLEAR;
		end

		// Fetch the cell one row below for the next scroll write
		if (cmd.sweep_rd) begin
			ram_raddr = cnt_q + ADDR_W'(COLUMNS);
		end

		if (cmd.cell_rd) begin
			ram_raddr = new_in_range ? cell_addr(in_data.read_row, in_data.read_col) : '0;
		end

		if (cmd.cell_cap && item_in_range) begin
			cell_d = ram_rdata;
		end

		if (cmd.sweep_wr) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q;
			ram_wdata = copy_cur ? ram_rdata : {sweep_attr, SPACE_CODE};
			cnt_d     = sts.cnt_last ? '0 : cnt_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			cnt_q        <= '0;
			kind_q       <= SW_INIT;
			blank_attr_q <= RESET_ATTR;
			out_valid_q  <= 1'b0;
		end else begin
			col_q  <= col_d;
			row_q  <= row_d;
			cnt_q  <= cnt_d;
			kind_q <= kind_d;
			if (cfg_wr_en) begin
				blank_attr_q <= cfg_wr_data;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			item_q <= in_data;
		end
		scrolled_q <= scrolled_d;
		cell_q     <= cell_d;
		if (cmd.load_out) begin
			out_q.cursor_col_out <= col_d;
			out_q.cursor_row_out <= row_d;
			out_q.scrolled       <= scrolled_d;
			out_q.cell_char      <= cell_d[CHAR_W-1:0];
			out_q.cell_attr      <= cell_d[CELL_W-1:CHAR_W];
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== verif/text_console_writer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer: puts, clears, reads and unused items go in
// over valid/ready and every result is checked against a screen shadow kept in the bench.
// Depends on tcw_pkg and the text_console_writer RTL.

module text_console_writer_tb;
	import tcw_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT = 3_000_000;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	in_item_t          in_data     = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	out_item_t         out_data;
	logic              cfg_wr_en   = 1'b0;
	logic [CHAR_W-1:0] cfg_wr_data = '0;

	// Screen shadow: cells, cursor and the blanking attribute
	logic [CELL_W-1:0] scr_cells [CELLS];
	int                scr_col;
	int                scr_row;
	logic [CHAR_W-1:0] scr_blank_attr;

	out_item_t cursor_reports_due [$];

	int     send_idle_pct  = 0;
	int     recv_stall_pct = 0;
	int     stall_req      = 0;
	int     stall_left     = 0;
	int     fail_count     = 0;
	int     items_sent     = 0;
	int     reads_sent     = 0;
	int     clears_sent    = 0;
	int     results_seen   = 0;
	int     scrolls_seen   = 0;
	longint cycle_count    = 0;

	text_console_writer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void blank_cells(input logic [CHAR_W-1:0] attr);
		for (int i = 0; i < CELLS; i++)
			scr_cells[i] = {attr, SPACE_CODE};
	endfunction

	// Apply one item to the shadow and return the result it should produce
	function automatic out_item_t console_step(input in_item_t it);
		out_item_t r;
		r = '0;
		case (it.opcode)
		OP_PUT: begin
			if (it.char_code == NEWLINE_CODE) begin
				scr_col = 0;
				scr_row++;
			end else if (it.char_code == BACKSPACE_CODE) begin
				if (scr_col > 0) begin
					scr_col--;
					scr_cells[scr_row * COLUMNS + scr_col] = {it.char_attr, SPACE_CODE};
				end
			end else begin
				scr_cells[scr_row * COLUMNS + scr_col] = {it.char_attr, it.char_code};
				scr_col++;
			end
			if (scr_col >= COLUMNS) begin
				scr_col = 0;
				scr_row++;
			end
			if (scr_row >= ROWS) begin
				// shift every row up one, blank the bottom row
				for (int i = 0; i < CELLS - COLUMNS; i++)
					scr_cells[i] = scr_cells[i + COLUMNS];
				for (int i = CELLS - COLUMNS; i < CELLS; i++)
					scr_cells[i] = {scr_blank_attr, SPACE_CODE};
				scr_row   = ROWS - 1;
				r.scrolled = 1'b1;
			end
		end
		OP_CLEAR: begin
			blank_cells(scr_blank_attr);
			scr_col = 0;
			scr_row = 0;
		end
		OP_READ: begin
			if (it.read_row < ROWS && it.read_col < COLUMNS)
				{r.cell_attr, r.cell_char} = scr_cells[it.read_row * COLUMNS + it.read_col];
		end
		default: ;
		endcase
		r.cursor_col_out = COL_W'(scr_col);
		r.cursor_row_out = ROW_W'(scr_row);
		return r;
	endfunction

	function automatic in_item_t compose(input logic [1:0] op, input logic [CHAR_W-1:0] ch,
			input logic [CHAR_W-1:0] attr, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		in_item_t it;
		it.opcode    = op;
		it.char_code = ch;
		it.char_attr = attr;
		it.read_row  = row;
		it.read_col  = col;
		return it;
	endfunction

	function automatic void check_field(input string name, input logic [CHAR_W-1:0] want,
			input logic [CHAR_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Offer one item, hold it until the transfer, then record what it must produce
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		cursor_reports_due.push_back(console_step(it));
		items_sent++;
		if (it.opcode == OP_READ)
			reads_sent++;
		if (it.opcode == OP_CLEAR)
			clears_sent++;
	endtask

	task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [CHAR_W-1:0] attr);
		send_item(compose(OP_PUT, ch, attr, ROW_W'($urandom_range(31)),
			COL_W'($urandom_range(127))));
	endtask

	task automatic read_cell(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
		send_item(compose(OP_READ, CHAR_W'($urandom_range(255)),
			CHAR_W'($urandom_range(255)), row, col));
	endtask

	// Drop valid, wait for every result and for the block to take items again
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (cursor_reports_due.size() != 0)
			@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_blank_attr(input logic [CHAR_W-1:0] v);
		settle_block();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		scr_blank_attr = v;
	endtask

	always @(negedge clk) begin
		if (stall_req > 0) begin
			stall_left = stall_req;
			stall_req  = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		out_item_t due;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (cursor_reports_due.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing pending, got %h", $time, out_data);
			end else begin
				due = cursor_reports_due.pop_front();
				check_field("cursor_col_out", CHAR_W'(due.cursor_col_out),
					CHAR_W'(out_data.cursor_col_out));
				check_field("cursor_row_out", CHAR_W'(due.cursor_row_out),
					CHAR_W'(out_data.cursor_row_out));
				check_field("scrolled", CHAR_W'(due.scrolled), CHAR_W'(out_data.scrolled));
				check_field("cell_char", due.cell_char, out_data.cell_char);
				check_field("cell_attr", due.cell_attr, out_data.cell_attr);
				if (due.scrolled)
					scrolls_seen++;
			end
		end
	end

	task automatic test_directed_ops();
		// backspace in column 0 leaves everything alone
		put_char(BACKSPACE_CODE, 8'hFF);
		put_char(8'hFF, 8'hFF);
		put_char(8'h00, 8'h00);
		put_char(8'h41, 8'h1E);
		put_char(BACKSPACE_CODE, 8'h70);
		read_cell(0, 0);
		read_cell(0, 1);
		read_cell(0, 2);
		put_char(NEWLINE_CODE, 8'h00);
		put_char(8'h7F, 8'h80);
		read_cell(1, 0);
		read_cell(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
		read_cell(ROW_W'(ROWS), 0);
		read_cell(0, COL_W'(COLUMNS));
		read_cell(5'h1F, 7'h7F);
		send_item(compose(OP_UNUSED, 8'hFF, 8'hFF, 5'h1F, 7'h7F));
		send_item(compose(OP_CLEAR, CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)),
			ROW_W'($urandom_range(31)), COL_W'($urandom_range(127))));
		read_cell(0, 0);
		read_cell(1, 0);
	endtask

	task automatic test_scroll_bottom();
		put_char(8'h31, 8'h12);
		put_char(NEWLINE_CODE, 8'h00);
		put_char(8'h32, 8'h34);
		repeat (ROWS - 2) put_char(NEWLINE_CODE, CHAR_W'($urandom_range(255)));
		put_char(8'h33, 8'h56);
		// leave the last row: everything moves up one
		put_char(NEWLINE_CODE, 8'hAA);
		put_char(BACKSPACE_CODE, 8'h55);
		read_cell(0, 0);
		read_cell(ROW_W'(ROWS - 2), 0);
		read_cell(ROW_W'(ROWS - 1), 0);
		read_cell(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
	endtask

	task automatic test_random_text(input int n);
		int          stop_at;
		int          kind;
		int          len;
		logic [1:0]  op;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				// a line of text with the odd correction and look-back
				len = $urandom_range(100, 1);
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(19))
					0: put_char(BACKSPACE_CODE, CHAR_W'($urandom_range(255)));
					1: read_cell(ROW_W'(scr_row), COL_W'($urandom_range(COLUMNS - 1)));
					default: put_char(CHAR_W'($urandom_range(255)),
						CHAR_W'($urandom_range(255)));
					endcase
				end
				if ($urandom_range(9) < 7)
					put_char(NEWLINE_CODE, CHAR_W'($urandom_range(255)));
			end else if (kind < 65) begin
				repeat ($urandom_range(6, 1))
					put_char(NEWLINE_CODE, CHAR_W'($urandom_range(255)));
			end else if (kind < 85) begin
				repeat ($urandom_range(6, 1)) begin
					if ($urandom_range(9) == 0)
						read_cell(ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
					else
						read_cell(ROW_W'($urandom_range(ROWS - 1)),
							COL_W'($urandom_range(COLUMNS - 1)));
				end
			end else if (kind < 98) begin
				// any opcode, any field; keep clears rare so the cursor gets deep
				repeat ($urandom_range(4, 1)) begin
					op = 2'($urandom_range(3));
					if (op == OP_CLEAR && $urandom_range(7) != 0)
						op = OP_UNUSED;
					send_item(compose(op, CHAR_W'($urandom_range(255)),
						CHAR_W'($urandom_range(255)),
						ROW_W'($urandom_range(31)), COL_W'($urandom_range(127))));
				end
			end else
				send_item(compose(OP_CLEAR, CHAR_W'($urandom_range(255)),
					CHAR_W'($urandom_range(255)),
					ROW_W'($urandom_range(31)), COL_W'($urandom_range(127))));
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		put_char(8'h42, 8'h24);
		// hold results back while items keep coming, so the input stalls
		stall_req = 400;
		repeat (30) begin
			put_char(CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)));
			read_cell(ROW_W'($urandom_range(ROWS - 1)), COL_W'($urandom_range(COLUMNS - 1)));
		end
		settle_block();
		repeat (10) begin
			put_char(CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)));
			read_cell(ROW_W'(scr_row), COL_W'($urandom_range(COLUMNS - 1)));
		end
	endtask

	initial begin
		blank_cells(RESET_ATTR);
		scr_col        = 0;
		scr_row        = 0;
		scr_blank_attr = RESET_ATTR;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_blank_attr(8'h3C);
		test_directed_ops();
		test_scroll_bottom();

		set_blank_attr(8'h00);
		test_random_text(360);

		set_blank_attr(8'hFF);
		send_idle_pct = 86;
		test_random_text(360);

		set_blank_attr(CHAR_W'($urandom_range(255)));
		send_idle_pct  = 0;
		recv_stall_pct = 86;
		test_random_text(360);

		set_blank_attr(8'h96);
		send_idle_pct  = 17;
		recv_stall_pct = 17;
		test_random_text(360);

		test_backpressure();

		settle_block();
		repeat (8) @(posedge clk);
		$display("Checked %0d results for %0d items: %0d reads, %0d clears, %0d scrolls,",
			results_seen, items_sent, reads_sent, clears_sent, scrolls_seen);
		$display("over five blanking attributes and four idle/stall mixes plus a long hold-off.");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_ctrl.sv
sv/tcw_dp.sv
sv/text_console_writer.sv
verif/text_console_writer_tb.sv
